// ===== rtl/sst_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted set table package
// Shared payload types, operation codes and chain link types.
// ----------------------------------------------------------------------------
package sst_pkg;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_QUERY  = 2'd2;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] value;
  } sst_in_t;

  typedef struct packed {
    logic       was_present;
    logic [4:0] set_size;
    logic       full_refused;
  } sst_out_t;

  typedef struct packed {
    logic               cmp_en;
    logic               ins;
    logic               rem;
    logic signed [31:0] key;
  } sst_ctl_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               lt;
    logic               ge;
  } sst_link_t;

  // The position below the first cell behaves as a held entry smaller than any key.
  localparam sst_link_t HEAD_LINK = '{value: 32'sd0, lt: 1'b1, ge: 1'b0};

endpackage

// ===== rtl/sst_cell.sv =====
// ----------------------------------------------------------------------------
// Sorted set table cell
// Holds one entry, compares it with the broadcast key and shifts toward
// either neighbor on an insert or a remove.
// ----------------------------------------------------------------------------
module sst_cell
  import sst_pkg::*;
#(
  parameter int IDX   = 0,
  parameter int CNT_W = 5
) (
  input  logic               clk,
  input  logic               rst_n,
  input  sst_ctl_t           ctl,
  input  logic [CNT_W-1:0]   count,
  input  sst_link_t          left,
  input  logic signed [31:0] right_value,
  output sst_link_t          link,
  output logic               eq
);

  logic signed [31:0] value_r, value_nxt;
  logic               lt_r, eq_r;
  logic               occ;

  assign occ = (count > CNT_W'(IDX));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lt_r <= 1'b0;
      eq_r <= 1'b0;
    end else if (ctl.cmp_en) begin
      lt_r <= occ & (value_r < ctl.key);
      eq_r <= occ & (value_r == ctl.key);
    end
  end

  always_comb begin
    value_nxt = value_r;
    if (ctl.ins) begin
      if (left.ge) begin
        value_nxt = left.value;
      end else if (left.lt && !lt_r) begin
        value_nxt = ctl.key;
      end
    end else if (ctl.rem && link.ge) begin
      value_nxt = right_value;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign link.value = value_r;
  assign link.lt    = lt_r;
  assign link.ge    = occ & ~lt_r;
  assign eq         = eq_r;

endmodule

// ===== rtl/sorted_set_table_top.sv =====
// ----------------------------------------------------------------------------
// Sorted set table
// Keeps up to CAPACITY distinct signed keys in ascending order and applies
// insert, remove and membership query operations, one result per item.
// ----------------------------------------------------------------------------
// On the accepting edge every cell of the chain registers its comparison
// with the key, and on the edge of the shift step the cells shift their
// entries one place up or down while the result is loaded into the output
// register. A new item is accepted only once the previous one has passed
// its shift step. A result held by the receiver stalls the shift step, and
// with it the input until that result is taken; one item may still be
// accepted and compared while the result waits. After reset the set is
// empty and no clearing pass is needed.
module sorted_set_table_top
  import sst_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  sst_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output sst_out_t out_data
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic               busy_r;
  logic [1:0]         mode_r;
  logic signed [31:0] key_r;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               out_valid_r;
  sst_out_t           out_r;

  logic [CAPACITY-1:0] eq_vec;
  sst_link_t           links [CAPACITY];
  sst_ctl_t            ctl;

  logic in_fire, exec_fire, present, full, do_ins, do_rem;

  assign in_ready  = ~busy_r;
  assign in_fire   = in_valid & in_ready;
  assign exec_fire = busy_r & (~out_valid_r | out_ready);

  assign present = |eq_vec;
  assign full    = (count_r == CNT_W'(CAPACITY));
  assign do_ins  = exec_fire & (mode_r == MODE_INSERT) & ~present & ~full;
  assign do_rem  = exec_fire & (mode_r == MODE_REMOVE) & present;

  always_comb begin
    count_nxt = count_r;
    if (do_ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_rem) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  assign ctl.cmp_en = in_fire;
  assign ctl.ins    = do_ins;
  assign ctl.rem    = do_rem;
  assign ctl.key    = busy_r ? key_r : in_data.value;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    sst_link_t          left;
    logic signed [31:0] right_value;

    if (g == 0) begin : g_head
      assign left = HEAD_LINK;
    end else begin : g_mid
      assign left = links[g-1];
    end

    if (g == CAPACITY - 1) begin : g_tail
      assign right_value = links[g].value;
    end else begin : g_body
      assign right_value = links[g+1].value;
    end

    sst_cell #(
      .IDX   (g),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .count       (count_r),
      .left        (left),
      .right_value (right_value),
      .link        (links[g]),
      .eq          (eq_vec[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        busy_r <= 1'b1;
      end else if (exec_fire) begin
        busy_r <= 1'b0;
      end
      count_r <= count_nxt;
      if (exec_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      mode_r <= in_data.mode;
      key_r  <= in_data.value;
    end
    if (exec_fire) begin
      out_r.was_present  <= present;
      out_r.set_size     <= 5'(count_nxt);
      out_r.full_refused <= (mode_r == MODE_INSERT) & ~present & full;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== rtl/sst_checker.sv =====
// ----------------------------------------------------------------------------
// Sorted set table checker
// Port-level assertions on the sorted set table, attached by a bind.
// ----------------------------------------------------------------------------
module sst_checker
  import sst_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input sst_out_t out_data
);

  // A result held by the consumer stays unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // An accepted transfer keeps the input closed for the following cycle.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input reopened while an item is in flight");

  // A refused insert concerns a value that was absent.
  a_refused_absent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.full_refused |-> !out_data.was_present)
    else $error("refused insert reports a present value");

  // A refused insert only happens with the table at capacity.
  a_refused_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.full_refused |-> out_data.set_size == 5'(CAPACITY))
    else $error("refused insert with table not full");

endmodule

bind sorted_set_table_top sst_checker #(
  .CAPACITY (CAPACITY)
) u_sst_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
